FILE: rtl/typed_unique_id_generator_top_defines.svh
// Assertion macros used by the generator top to check its stream handshakes.
`ifndef TYPED_UNIQUE_ID_GENERATOR_TOP_DEFINES_SVH
`define TYPED_UNIQUE_ID_GENERATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UIDG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uidg check failed");

// The consequent must hold in the cycle after the antecedent.
`define UIDG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uidg check failed");

`endif

FILE: rtl/uidg_pkg.sv
package uidg_pkg;

    localparam int CNT_W  = 24;
    localparam int TAG_W  = 32;
    localparam int TYPE_W = 6;
    localparam int KIND_W = 2;
    localparam int GUID_W = 64;

    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET     = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_MAX     = 24'hFFFFFF;
    localparam logic [CNT_W-1:0] SWITCH_LIMIT  = 24'h00FFFF;
    localparam logic [CNT_W-1:0] REQUEST_LIMIT = 24'h008000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TYPE_W-1:0] type_id;
        logic [TAG_W-1:0]  tag_value;
    } item_t;

    typedef struct packed {
        logic [GUID_W-1:0] guid;
        logic              granted;
        logic              need_next_tag;
    } result_t;

    typedef struct packed {
        logic             wr;
        logic             clr;
        logic [CNT_W-1:0] cnt;
    } cnt_wr_t;

endpackage

FILE: rtl/uidg_cnt_mem.sv
module uidg_cnt_mem
    import uidg_pkg::*;
#(
    parameter int NUM_TYPES = 64,
    localparam int IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    input  cnt_wr_t          wr,
    input  logic [IDX_W-1:0] wr_idx,
    output logic [CNT_W-1:0] cnt
);

    logic [CNT_W-1:0]     mem [NUM_TYPES];
    logic [NUM_TYPES-1:0] valid_reg;
    logic [CNT_W-1:0]     rd_raw_reg;
    logic [CNT_W-1:0]     byp_cnt_reg;
    logic                 byp_reg;
    logic                 zero_reg;
    logic                 byp_next;
    logic                 zero_next;
    logic                 rd_in_range;

    // A read in the same cycle as a write or clear takes the new contents.
    assign rd_in_range = (32'(rd_idx) < NUM_TYPES);
    assign byp_next    = !wr.clr && wr.wr && (wr_idx == rd_idx);
    assign zero_next   = wr.clr || (!byp_next && !(rd_in_range && valid_reg[rd_idx]));

    always_ff @(posedge clk)
    begin
        if (wr.wr)
        begin
            mem[wr_idx] <= wr.cnt;
        end
        if (rd_en)
        begin
            rd_raw_reg  <= mem[rd_idx];
            byp_cnt_reg <= wr.cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            byp_reg   <= 1'b0;
            zero_reg  <= 1'b1;
        end
        else
        begin
            if (wr.clr)
            begin
                valid_reg <= '0;
            end
            else if (wr.wr)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                byp_reg  <= byp_next;
                zero_reg <= zero_next;
            end
        end
    end

    assign cnt = zero_reg ? '0 : (byp_reg ? byp_cnt_reg : rd_raw_reg);

endmodule

FILE: rtl/uidg_core.sv
module uidg_core
    import uidg_pkg::*;
#(
    parameter int NUM_TYPES = 64,
    localparam int IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  item_t            item,
    input  logic [CNT_W-1:0] cnt,
    output result_t          res,
    output cnt_wr_t          wr,
    output logic [IDX_W-1:0] wr_idx
);

    logic [CNT_W-1:0] highest_reg;
    logic [CNT_W-1:0] highest_next;
    logic [TAG_W-1:0] cur_tag_reg;
    logic [TAG_W-1:0] cur_tag_next;
    logic [TAG_W-1:0] next_tag_reg;
    logic [TAG_W-1:0] next_tag_next;
    logic             next_valid_reg;
    logic             next_valid_next;
    logic             pend_reg;
    logic             pend_next;
    logic [CNT_W-1:0] inc;
    logic [CNT_W-1:0] count_out;
    logic             in_range;
    logic             ok;
    logic             wr_en;
    logic             clr;

    assign in_range = (32'(item.type_id) < NUM_TYPES);
    assign inc      = cnt + CNT_W'(1);
    assign ok       = (item.kind == KIND_REQUEST) && in_range && (cnt < COUNT_MAX)
                      && (cur_tag_reg != '0);
    assign wr_idx   = IDX_W'(item.type_id);

    always_comb
    begin
        highest_next    = highest_reg;
        cur_tag_next    = cur_tag_reg;
        next_tag_next   = next_tag_reg;
        next_valid_next = next_valid_reg;
        pend_next       = pend_reg;
        count_out       = inc;
        wr_en           = 1'b0;
        clr             = 1'b0;
        unique case (item.kind)
            KIND_REQUEST:
            begin
                if (ok)
                begin
                    wr_en = 1'b1;
                    if (inc > highest_reg)
                    begin
                        highest_next = inc;
                        if ((inc > REQUEST_LIMIT) && !pend_reg && !next_valid_reg)
                        begin
                            pend_next = 1'b1;
                        end
                        if ((inc > SWITCH_LIMIT) && next_valid_reg)
                        begin
                            cur_tag_next    = next_tag_reg;
                            next_valid_next = 1'b0;
                            clr             = 1'b1;
                            highest_next    = '0;
                            count_out       = '0;
                        end
                    end
                end
            end
            KIND_RESERVE:
            begin
                pend_next = 1'b0;
                if (highest_reg >= SWITCH_LIMIT)
                begin
                    cur_tag_next    = item.tag_value;
                    next_valid_next = 1'b0;
                    next_tag_next   = '0;
                    clr             = 1'b1;
                    highest_next    = '0;
                end
                else
                begin
                    next_valid_next = 1'b1;
                    next_tag_next   = item.tag_value;
                end
            end
            KIND_SET:
            begin
                cur_tag_next    = item.tag_value;
                pend_next       = 1'b0;
                next_valid_next = 1'b0;
                next_tag_next   = '0;
                clr             = 1'b1;
                highest_next    = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            highest_reg    <= '0;
            cur_tag_reg    <= '0;
            next_tag_reg   <= '0;
            next_valid_reg <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else if (fire)
        begin
            highest_reg    <= highest_next;
            cur_tag_reg    <= cur_tag_next;
            next_tag_reg   <= next_tag_next;
            next_valid_reg <= next_valid_next;
            pend_reg       <= pend_next;
        end
    end

    assign wr.wr  = fire && wr_en;
    assign wr.clr = fire && clr;
    assign wr.cnt = count_out;

    assign res.guid          = ok ? {cur_tag_next, (8 - TYPE_W)'(0), item.type_id, count_out}
                                  : '0;
    assign res.granted       = ok;
    assign res.need_next_tag = pend_next;

endmodule

FILE: rtl/typed_unique_id_generator_top.sv
// Typed unique identifier generator.
// The slave stream carries one item per transfer: s_tuser holds the kind (request,
// reserve next tag, set tag now) and s_tdata holds the type and the time tag.
// Every item gives exactly one result item on the master stream: the 64-bit
// identifier in m_tdata, and the granted and need-next-tag flags in m_tuser.
// An accepted item is registered while its type counter is read from the counter
// memory at the same edge; the result register is loaded from them when the item
// advances, which a stalled receiver can delay.
// One item per cycle is sustained while the receiver takes results; the separate
// read and write ports of the counter memory with a write-to-read bypass allow
// that rate, and clears of all counters are done at once through per-type valid flops.
// Reset empties both stages, clears all counters, tags and flags; no clearing
// pass is needed. When the receiver stalls, the result register holds its item,
// one more item may wait in the input register, and then s_tready drops.
`include "typed_unique_id_generator_top_defines.svh"

module typed_unique_id_generator_top
    import uidg_pkg::*;
#(
    parameter int NUM_TYPES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // type_id[5:0], tag_value[37:6], zero fill
    input  logic [1:0]  s_tuser,  // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // guid[63:0]
    output logic [1:0]  m_tuser   // granted[0], need_next_tag[1]
);

    localparam int IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

    logic             in_valid_reg;
    item_t            item_reg;
    item_t            item_next;
    logic             out_valid_reg;
    result_t          out_reg;
    result_t          res;
    cnt_wr_t          wr;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] cnt;
    logic             adv;
    logic             in_fire;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign in_fire  = s_tvalid && s_tready;

    assign item_next.kind      = s_tuser;
    assign item_next.type_id   = s_tdata[5:0];
    assign item_next.tag_value = s_tdata[37:6];

    uidg_cnt_mem #(
        .NUM_TYPES (NUM_TYPES)
    ) u_cnt_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (in_fire),
        .rd_idx (IDX_W'(item_next.type_id)),
        .wr     (wr),
        .wr_idx (wr_idx),
        .cnt    (cnt)
    );

    uidg_core #(
        .NUM_TYPES (NUM_TYPES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (adv),
        .item   (item_reg),
        .cnt    (cnt),
        .res    (res),
        .wr     (wr),
        .wr_idx (wr_idx)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= item_next;
        end
        if (adv)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.guid;
    assign m_tuser[0] = out_reg.granted;
    assign m_tuser[1] = out_reg.need_next_tag;

    `UIDG_ASSERT_SAME(a_fail_zero, m_tvalid && !m_tuser[0], m_tdata == 64'd0)
    `UIDG_ASSERT_SAME(a_stall_cause, !s_tready, in_valid_reg && out_valid_reg && !m_tready)
    `UIDG_ASSERT_NEXT(a_drain, m_tvalid && m_tready && !in_valid_reg, !m_tvalid)

endmodule
